/* rtl/aavr_pkg.sv */
// Package for the axis-angle vector rotator: fixed-point constants and helpers.
// Used by aavr_cordic and axis_angle_vector_rotate; depends on nothing.
package aavr_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int Q30               = 30;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Arctangent of 2^-i at 30 fraction bits
    function automatic longint atan_q30(input int i);
        longint t;
        case (i)
            0:  t = 843314857;
            1:  t = 497837829;
            2:  t = 263043837;
            3:  t = 133525159;
            4:  t = 67021687;
            5:  t = 33543516;
            6:  t = 16775851;
            7:  t = 8388437;
            8:  t = 4194283;
            9:  t = 2097149;
            default: t = longint'(1) <<< (Q30 - i);
        endcase
        return t;
    endfunction

    // Round a Q30 constant half up to f fraction bits (elaboration only)
    function automatic longint q30_to_f(input longint v, input int f);
        return (v + (longint'(1) <<< (Q30 - f - 1))) >>> (Q30 - f);
    endfunction

    // Integer square root (elaboration only)
    function automatic longint unsigned isqrt64(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unsigned quotient by shift and subtract (elaboration only)
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                q   = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    // Reciprocal of the CORDIC gain at 30 fraction bits for a given stage count
    function automatic longint gain_q30(input int stages);
        longint unsigned p;
        longint unsigned s;
        p = 64'd1 << 40;
        for (int i = 0; i < stages && i < ATAN_ENTRIES; i++)
            p = p + (p >> (2 * i));
        s = isqrt64(p << 20);
        return longint'(udiv64((64'd1 << 60) + (s >> 1), s));
    endfunction

endpackage

/* rtl/aavr_cordic.sv */
// Pipelined CORDIC rotator, one stage per register, giving cos and sin.
// Depends on aavr_pkg. Carries a side payload of PW bits alongside.
module aavr_cordic #(
    parameter int STAGES = aavr_pkg::CORDIC_STAGES_DEF,
    parameter int FB     = aavr_pkg::FRACTION_BITS_DEF,
    parameter int PW     = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [FB+2:0] angle,
    input  logic [PW-1:0]        pay_in,
    output logic                 out_valid,
    output logic signed [FB+2:0] cos_o,
    output logic signed [FB+2:0] sin_o,
    output logic [PW-1:0]        pay_out
);
    localparam int W = FB + 3;
    localparam longint PI_F   = aavr_pkg::q30_to_f(aavr_pkg::PI_Q30, FB);
    localparam longint HP_F   = aavr_pkg::q30_to_f(aavr_pkg::HALF_PI_Q30, FB);
    localparam longint GAIN_F = aavr_pkg::q30_to_f(aavr_pkg::gain_q30(STAGES), FB);

    logic signed [W-1:0] x_reg [0:STAGES];
    logic signed [W-1:0] y_reg [0:STAGES];
    logic signed [W:0]   z_reg [0:STAGES];
    logic                neg_reg [0:STAGES];
    logic                vld_reg [0:STAGES];
    logic [PW-1:0]       pay_reg [0:STAGES];

    logic signed [W:0]   z0_next;
    logic                neg0_next;

    // Fold the angle into minus pi/2 .. pi/2
    always_comb
    begin
        z0_next   = (W+1)'(angle);
        neg0_next = 1'b0;
        if (64'(signed'(angle)) > HP_F)
        begin
            z0_next   = (W+1)'(64'(signed'(angle)) - PI_F);
            neg0_next = 1'b1;
        end
        else if (64'(signed'(angle)) < -HP_F)
        begin
            z0_next   = (W+1)'(64'(signed'(angle)) + PI_F);
            neg0_next = 1'b1;
        end
    end

    // Load the first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= W'(GAIN_F);
            y_reg[0]   <= '0;
            z_reg[0]   <= z0_next;
            neg_reg[0] <= neg0_next;
            pay_reg[0] <= pay_in;
        end
    end

    // Advance through the rotation stages
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam longint AT = aavr_pkg::q30_to_f(aavr_pkg::atan_q30(i), FB);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][W])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - (W+1)'(AT);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + (W+1)'(AT);
                end
                neg_reg[i+1] <= neg_reg[i];
                pay_reg[i+1] <= pay_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign cos_o     = neg_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
    assign sin_o     = neg_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
    assign pay_out   = pay_reg[STAGES];

endmodule

/* rtl/axis_angle_vector_rotate.sv */
// Top level of the axis-angle vector rotator (Rodrigues formula).
// Depends on aavr_pkg and aavr_cordic.
//
// Rotates a Q15.16 vector about a unit axis (Q1.16, not normalised) by an
// angle in Q2.16 radians. One request is taken every clock cycle while the
// output register is empty or being taken; each result passes through the
// CORDIC pipeline (a load stage plus one stage per iteration) followed by
// matrix-build and multiply-accumulate stages. The whole pipe advances when
// the output register is empty or being taken, so a stalled result holds
// everything behind it. saturated flags clipping.
module axis_angle_vector_rotate #(
    parameter int CORDIC_STAGES = aavr_pkg::CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = aavr_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // angle[18:0], axis_x[36:19], axis_y[54:37], axis_z[72:55],
    // vec_x[104:73], vec_y[136:105], vec_z[168:137], zeros up to 175
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // saturated
    output logic         m_axis_tuser
);
    localparam int F  = FRACTION_BITS;
    localparam int AW = F + 3;             // angle / cos / sin width
    localparam int UW = F + 2;             // axis width
    localparam int PW = 3 * UW + 96;
    localparam int MW = F + 4;             // outer product entry width

    // Convert Q16 input to F fraction bits, rounding half up when narrowing
    function automatic logic signed [UW:0] cvt(input logic signed [18:0] v);
        logic signed [63:0] t;
        t = 64'(v);
        if (F >= 16)
            t = t <<< (F - 16);
        else
            t = (t + (64'sd1 <<< (15 - F + ((F >= 16) ? 0 : 0)))) >>> (16 - F);
        return (UW+1)'(t);
    endfunction

    logic en;
    logic out_vld_reg;
    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [AW-1:0] ang_in;
    logic [PW-1:0] pay_in;
    logic signed [UW:0] ax_c;
    logic signed [UW:0] ay_c;
    logic signed [UW:0] az_c;
    logic signed [UW:0] an_c;
    assign an_c = cvt(s_axis_tdata[18:0]);
    assign ax_c = cvt({s_axis_tdata[36], s_axis_tdata[36:19]});
    assign ay_c = cvt({s_axis_tdata[54], s_axis_tdata[54:37]});
    assign az_c = cvt({s_axis_tdata[72], s_axis_tdata[72:55]});
    assign ang_in = AW'(an_c);
    assign pay_in = {s_axis_tdata[168:73], UW'(az_c), UW'(ay_c), UW'(ax_c)};

    logic c_vld;
    logic signed [AW-1:0] c_cos;
    logic signed [AW-1:0] c_sin;
    logic [PW-1:0] c_pay;

    aavr_cordic #(
        .STAGES (CORDIC_STAGES),
        .FB     (F),
        .PW     (PW)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .angle     (ang_in),
        .pay_in    (pay_in),
        .out_valid (c_vld),
        .cos_o     (c_cos),
        .sin_o     (c_sin),
        .pay_out   (c_pay)
    );

    logic signed [UW-1:0] u [0:2];
    logic signed [31:0]   v [0:2];
    assign u[0] = c_pay[UW-1:0];
    assign u[1] = c_pay[2*UW-1:UW];
    assign u[2] = c_pay[3*UW-1:2*UW];
    assign v[0] = c_pay[3*UW+31:3*UW];
    assign v[1] = c_pay[3*UW+63:3*UW+32];
    assign v[2] = c_pay[3*UW+95:3*UW+64];

    // Stage A: outer product u*u^T, rounded; hold cos, sin, the axis for the skew terms, and the vector
    logic                 a_vld_reg;
    logic signed [MW-1:0] a_m_reg [0:2][0:2];
    logic signed [AW-1:0] a_c_reg;
    logic signed [AW-1:0] a_s_reg;
    logic signed [UW-1:0] a_u_reg [0:2];
    logic signed [31:0]   a_v_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= c_vld;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_a
        for (genvar j = 0; j < 3; j++)
        begin : g_aj
            logic signed [2*UW-1:0] p;
            assign p = u[i] * u[j];
            always_ff @(posedge clk)
            begin
                if (en)
                    a_m_reg[i][j] <= MW'((p + (2*UW)'(64'sd1 <<< (F - 1))) >>> F);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_u_reg[i] <= u[i];
                a_v_reg[i] <= v[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_c_reg <= c_cos;
            a_s_reg <= c_sin;
        end
    end

    // Stage B: cos*(delta-uu) and sin*skew, rounded
    logic                 b_vld_reg;
    logic signed [MW-1:0] b_m_reg [0:2][0:2];
    logic signed [MW+1:0] b_c_reg [0:2][0:2];
    logic signed [MW+1:0] b_s_reg [0:2][0:2];
    logic signed [31:0]   b_v_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_b
        for (genvar j = 0; j < 3; j++)
        begin : g_bj
            logic signed [MW+1:0] d;
            logic signed [UW:0]   sk;
            logic signed [MW+AW+1:0] pc;
            logic signed [UW+AW:0]   ps;
            assign d = ((i == j) ? (MW+2)'(64'sd1 <<< F) : '0) - (MW+2)'(a_m_reg[i][j]);
            if (i == j)
            begin : g_z
                assign sk = '0;
            end
            else if ((i == 0 && j == 1) || (i == 1 && j == 2) || (i == 2 && j == 0))
            begin : g_n
                assign sk = -(UW+1)'(a_u_reg[3 - i - j]);
            end
            else
            begin : g_p
                assign sk = (UW+1)'(a_u_reg[3 - i - j]);
            end
            assign pc = a_c_reg * d;
            assign ps = a_s_reg * sk;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    b_m_reg[i][j] <= a_m_reg[i][j];
                    b_c_reg[i][j] <= (MW+2)'((pc + (MW+AW+2)'(64'sd1 <<< (F-1))) >>> F);
                    b_s_reg[i][j] <= (MW+2)'((ps + (UW+AW+1)'(64'sd1 <<< (F-1))) >>> F);
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                b_v_reg[i] <= a_v_reg[i];
        end
    end

    // Stage C: sum into R entries
    logic                 r_vld_reg;
    logic signed [MW+3:0] r_reg [0:2][0:2];
    logic signed [31:0]   r_v_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_vld_reg <= 1'b0;
        else if (en)
            r_vld_reg <= b_vld_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_r
        for (genvar j = 0; j < 3; j++)
        begin : g_rj
            always_ff @(posedge clk)
            begin
                if (en)
                    r_reg[i][j] <= (MW+4)'(b_m_reg[i][j]) + (MW+4)'(b_c_reg[i][j])
                                 + (MW+4)'(b_s_reg[i][j]);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                r_v_reg[i] <= b_v_reg[i];
        end
    end

    // Stage D: products R_ij * v_j
    logic                  p_vld_reg;
    logic signed [MW+35:0] p_reg [0:2][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= r_vld_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_p
        for (genvar j = 0; j < 3; j++)
        begin : g_pj
            always_ff @(posedge clk)
            begin
                if (en)
                    p_reg[i][j] <= r_reg[i][j] * r_v_reg[j];
            end
        end
    end

    // Stage E: sum, round, saturate into the output register
    logic [31:0] out_reg [0:2];
    logic [2:0]  sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= p_vld_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_o
        logic signed [MW+37:0] acc;
        logic signed [MW+37:0] rnd;
        assign acc = (MW+38)'(p_reg[i][0]) + (MW+38)'(p_reg[i][1]) + (MW+38)'(p_reg[i][2]);
        assign rnd = (acc + (MW+38)'(64'sd1 <<< (F-1))) >>> F;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rnd > (MW+38)'(64'sd2147483647))
                begin
                    out_reg[i] <= 32'h7FFF_FFFF;
                    sat_reg[i] <= 1'b1;
                end
                else if (rnd < -(MW+38)'(64'sd2147483648))
                begin
                    out_reg[i] <= 32'h8000_0000;
                    sat_reg[i] <= 1'b1;
                end
                else
                begin
                    out_reg[i] <= rnd[31:0];
                    sat_reg[i] <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_axis_tuser  = |sat_reg;

`ifndef SYNTH
    // A stalled result must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // Input ready follows the output register
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready out of step with output register");

    // A raised flag means some component sits at a rail
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000
          || m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000
          || m_axis_tdata[95:64] == 32'h7FFF_FFFF || m_axis_tdata[95:64] == 32'h8000_0000))
        else $error("saturation flag without a clipped component");
`endif

endmodule
